[hw/rtl/tksd_pkg.sv]
// Shared types and key codes for the terminal key sequence decoder.
`timescale 1ns / 1ps
package tksd_pkg;

  localparam logic [4:0] K_NONE      = 5'd0;
  localparam logic [4:0] K_CHAR      = 5'd1;
  localparam logic [4:0] K_ENTER     = 5'd2;
  localparam logic [4:0] K_BACK      = 5'd3;
  localparam logic [4:0] K_INTR      = 5'd4;
  localparam logic [4:0] K_EOF       = 5'd5;
  localparam logic [4:0] K_HOME      = 5'd6;
  localparam logic [4:0] K_END       = 5'd7;
  localparam logic [4:0] K_LEFT      = 5'd8;
  localparam logic [4:0] K_RIGHT     = 5'd9;
  localparam logic [4:0] K_UP        = 5'd10;
  localparam logic [4:0] K_DOWN      = 5'd11;
  localparam logic [4:0] K_KILLSTART = 5'd12;
  localparam logic [4:0] K_KILLEND   = 5'd13;
  localparam logic [4:0] K_KILLWORD  = 5'd14;
  localparam logic [4:0] K_CLEAR     = 5'd15;
  localparam logic [4:0] K_WLEFT     = 5'd16;
  localparam logic [4:0] K_WRIGHT    = 5'd17;
  localparam logic [4:0] K_DELETE    = 5'd18;
  localparam logic [4:0] K_IGNORED   = 5'd19;

  localparam logic [7:0] B_ESC = 8'h1b;
  localparam logic [7:0] B_DEL = 8'h7f;
  localparam logic [7:0] B_BS  = 8'h08;
  localparam logic [7:0] B_TAB = 8'h09;

  // Classified input byte handed from the front end to the decoder.
  typedef struct packed {
    logic [7:0] data;
    logic [4:0] gkey;
    logic       is_tab;
    logic       is_esc;
    logic       is_lead;
    logic [1:0] owed;
    logic       is_cont;
  } tksd_item_t;

endpackage

[hw/rtl/tksd_front.sv]
// Input stage: accepts raw bytes and classifies them for ground-state decoding.
`timescale 1ns / 1ps
module tksd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_byte,
  output logic              push_valid,
  input  logic              push_ready,
  output tksd_pkg::tksd_item_t push_item
);
  import tksd_pkg::*;

  logic       valid_r, valid_nxt;
  tksd_item_t item_r;
  tksd_item_t cls;
  logic       accept;

  always_comb begin
    cls         = '0;
    cls.data    = in_byte;
    cls.is_cont = (in_byte[7:6] == 2'b10);
    case (in_byte)
      B_ESC: begin
        cls.gkey   = K_NONE;
        cls.is_esc = 1'b1;
      end
      8'h0d, 8'h0a: cls.gkey = K_ENTER;
      B_DEL, B_BS:  cls.gkey = K_BACK;
      8'h03: cls.gkey = K_INTR;
      8'h04: cls.gkey = K_EOF;
      8'h01: cls.gkey = K_HOME;
      8'h05: cls.gkey = K_END;
      8'h02: cls.gkey = K_LEFT;
      8'h06: cls.gkey = K_RIGHT;
      8'h10: cls.gkey = K_UP;
      8'h0e: cls.gkey = K_DOWN;
      8'h15: cls.gkey = K_KILLSTART;
      8'h0b: cls.gkey = K_KILLEND;
      8'h17: cls.gkey = K_KILLWORD;
      8'h0c: cls.gkey = K_CLEAR;
      B_TAB: begin
        cls.gkey   = K_CHAR;
        cls.is_tab = 1'b1;
      end
      default: begin
        if (in_byte < 8'h20) begin
          cls.gkey = K_IGNORED;
        end else if (in_byte < 8'h80) begin
          cls.gkey = K_CHAR;
        end else if ((in_byte & 8'he0) == 8'hc0) begin
          cls.gkey    = K_NONE;
          cls.is_lead = 1'b1;
          cls.owed    = 2'd1;
        end else if ((in_byte & 8'hf0) == 8'he0) begin
          cls.gkey    = K_NONE;
          cls.is_lead = 1'b1;
          cls.owed    = 2'd2;
        end else if ((in_byte & 8'hf8) == 8'hf0) begin
          cls.gkey    = K_NONE;
          cls.is_lead = 1'b1;
          cls.owed    = 2'd3;
        end else begin
          cls.gkey = K_IGNORED;
        end
      end
    endcase
  end

  assign in_tready  = !valid_r || push_ready;
  assign accept     = in_tvalid && in_tready;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      item_r <= cls;
    end
  end

endmodule

[hw/rtl/tksd_queue.sv]
// Two-entry queue between the classifying front end and the decoder.
`timescale 1ns / 1ps
module tksd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  tksd_pkg::tksd_item_t wr_item,
  output logic              rd_valid,
  input  logic              rd_pop,
  output tksd_pkg::tksd_item_t rd_item
);
  import tksd_pkg::*;

  tksd_item_t slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = slot_r[rptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_comb begin
    wptr_nxt = do_wr ? !wptr_r : wptr_r;
    rptr_nxt = do_rd ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_wr) begin
      slot_r[wptr_r] <= wr_item;
    end
  end

endmodule

[hw/rtl/tksd_back.sv]
// Decoder: escape, CSI, SS3 and UTF-8 state with a registered key event output.
`timescale 1ns / 1ps
module tksd_back #(
  parameter int TAB_SPACES  = 4,
  parameter int PARAM_LIMIT = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  tksd_pkg::tksd_item_t q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [4:0]        key_code,
  output logic [63:0]       text_bytes,
  output logic [3:0]        text_len
);
  import tksd_pkg::*;

  localparam int PCW = $clog2(PARAM_LIMIT + 1);

  typedef enum logic [2:0] {
    M_GROUND = 3'd0,
    M_ESC    = 3'd1,
    M_CSI    = 3'd2,
    M_SS3    = 3'd3,
    M_UTF8   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    PC_EMPTY = 3'd0,
    PC_HOME  = 3'd1,
    PC_END   = 3'd2,
    PC_DEL   = 3'd3,
    PC_FHOME = 3'd4,
    PC_FEND  = 3'd5,
    PC_FDEL  = 3'd6,
    PC_DEAD  = 3'd7
  } pclass_t;

  mode_t          mode_r, mode_nxt;
  logic [23:0]    pend_r, pend_nxt;
  logic [1:0]     pcnt_r, pcnt_nxt;
  logic [1:0]     owed_r, owed_nxt;
  logic [PCW-1:0] parc_r, parc_nxt;
  logic           semi_r, semi_nxt;
  logic           ctrl_r, ctrl_nxt;
  pclass_t        pcls_r, pcls_nxt;

  logic           ovalid_r, ovalid_nxt;
  logic [4:0]     key_r, key_nxt;
  logic [63:0]    text_r, text_nxt;
  logic [3:0]     len_r, len_nxt;

  logic [63:0]    tab_text;
  logic [7:0]     b;
  logic [4:0]     final_key;
  logic [23:0]    pend_add;

  assign q_pop      = q_valid && (!ovalid_r || out_ready);
  assign b          = q_item.data;
  assign out_valid  = ovalid_r;
  assign key_code   = key_r;
  assign text_bytes = text_r;
  assign text_len   = len_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tab_text[8*i +: 8] = (i < TAB_SPACES) ? 8'h20 : 8'h00;
    end
  end

  always_comb begin
    case (b)
      "A": final_key = K_UP;
      "B": final_key = K_DOWN;
      "C": final_key = ctrl_r ? K_WRIGHT : K_RIGHT;
      "D": final_key = ctrl_r ? K_WLEFT : K_LEFT;
      "H": final_key = K_HOME;
      "F": final_key = K_END;
      "~": begin
        case (pcls_r)
          PC_HOME, PC_FHOME: final_key = K_HOME;
          PC_END, PC_FEND:   final_key = K_END;
          PC_DEL, PC_FDEL:   final_key = K_DELETE;
          default:           final_key = K_IGNORED;
        endcase
      end
      default: final_key = K_IGNORED;
    endcase
  end

  always_comb begin
    case (pcnt_r)
      2'd1:    pend_add = {8'h00, b, 8'h00};
      2'd2:    pend_add = {b, 16'h0000};
      default: pend_add = {16'h0000, b};
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    owed_nxt = owed_r;
    parc_nxt = parc_r;
    semi_nxt = semi_r;
    ctrl_nxt = ctrl_r;
    pcls_nxt = pcls_r;
    key_nxt  = K_NONE;
    text_nxt = '0;
    len_nxt  = 4'd0;

    case (mode_r)
      M_GROUND, M_UTF8: begin
        if (mode_r == M_UTF8 && q_item.is_cont) begin
          if (pcnt_r == 2'd3 || owed_r == 2'd0) begin
            mode_nxt = M_GROUND;
            pend_nxt = '0;
            pcnt_nxt = 2'd0;
            owed_nxt = 2'd0;
            parc_nxt = '0;
            semi_nxt = 1'b0;
            ctrl_nxt = 1'b0;
            pcls_nxt = PC_EMPTY;
            key_nxt  = K_IGNORED;
          end else if (owed_r != 2'd1) begin
            pend_nxt = pend_r | pend_add;
            pcnt_nxt = pcnt_r + 2'd1;
            owed_nxt = owed_r - 2'd1;
          end else begin
            text_nxt = {40'h0, pend_r | pend_add};
            len_nxt  = {2'b00, pcnt_r} + 4'd1;
            key_nxt  = K_CHAR;
            pend_nxt = '0;
            pcnt_nxt = 2'd0;
            owed_nxt = 2'd0;
            mode_nxt = M_GROUND;
          end
        end else begin
          // A byte in ground, or a non-continuation byte that drops a partial character.
          if (mode_r == M_UTF8) begin
            mode_nxt = M_GROUND;
            pend_nxt = '0;
            pcnt_nxt = 2'd0;
            owed_nxt = 2'd0;
            parc_nxt = '0;
            semi_nxt = 1'b0;
            ctrl_nxt = 1'b0;
            pcls_nxt = PC_EMPTY;
          end
          key_nxt = q_item.gkey;
          if (q_item.is_tab) begin
            text_nxt = tab_text;
            len_nxt  = 4'(TAB_SPACES);
          end else if (q_item.gkey == K_CHAR) begin
            text_nxt = {56'h0, b};
            len_nxt  = 4'd1;
          end
          if (q_item.is_esc) begin
            mode_nxt = M_ESC;
          end
          if (q_item.is_lead) begin
            mode_nxt = M_UTF8;
            pend_nxt = {16'h0000, b};
            pcnt_nxt = 2'd1;
            owed_nxt = q_item.owed;
          end
        end
      end
      M_ESC: begin
        parc_nxt = '0;
        semi_nxt = 1'b0;
        ctrl_nxt = 1'b0;
        pcls_nxt = PC_EMPTY;
        mode_nxt = M_GROUND;
        if (b == "[") begin
          mode_nxt = M_CSI;
        end else if (b == "O") begin
          mode_nxt = M_SS3;
        end else if (b == "b" || b == "B") begin
          key_nxt = K_WLEFT;
        end else if (b == "f" || b == "F") begin
          key_nxt = K_WRIGHT;
        end else begin
          key_nxt = K_IGNORED;
        end
      end
      M_CSI: begin
        if (b >= 8'h20 && b <= 8'h3f) begin
          if (parc_r < PCW'(PARAM_LIMIT)) begin
            if (semi_r && b == "5") begin
              ctrl_nxt = 1'b1;
            end
            semi_nxt = (b == ";");
            case (pcls_r)
              PC_EMPTY: begin
                if (b == "1" || b == "7") begin
                  pcls_nxt = PC_HOME;
                end else if (b == "4" || b == "8") begin
                  pcls_nxt = PC_END;
                end else if (b == "3") begin
                  pcls_nxt = PC_DEL;
                end else begin
                  pcls_nxt = PC_DEAD;
                end
              end
              PC_HOME: pcls_nxt = (b == ";") ? PC_FHOME : PC_DEAD;
              PC_END:  pcls_nxt = (b == ";") ? PC_FEND : PC_DEAD;
              PC_DEL:  pcls_nxt = (b == ";") ? PC_FDEL : PC_DEAD;
              default: pcls_nxt = pcls_r;
            endcase
            parc_nxt = parc_r + PCW'(1);
          end
        end else begin
          mode_nxt = M_GROUND;
          key_nxt  = final_key;
        end
      end
      M_SS3: begin
        mode_nxt = M_GROUND;
        key_nxt  = final_key;
      end
      default: begin
        mode_nxt = M_GROUND;
        pend_nxt = '0;
        pcnt_nxt = 2'd0;
        owed_nxt = 2'd0;
        parc_nxt = '0;
        semi_nxt = 1'b0;
        ctrl_nxt = 1'b0;
        pcls_nxt = PC_EMPTY;
        key_nxt  = K_IGNORED;
      end
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (q_pop) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_GROUND;
      pend_r   <= '0;
      pcnt_r   <= 2'd0;
      owed_r   <= 2'd0;
      parc_r   <= '0;
      semi_r   <= 1'b0;
      ctrl_r   <= 1'b0;
      pcls_r   <= PC_EMPTY;
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      if (q_pop) begin
        mode_r <= mode_nxt;
        pend_r <= pend_nxt;
        pcnt_r <= pcnt_nxt;
        owed_r <= owed_nxt;
        parc_r <= parc_nxt;
        semi_r <= semi_nxt;
        ctrl_r <= ctrl_nxt;
        pcls_r <= pcls_nxt;
      end
    end
    if (q_pop) begin
      key_r  <= key_nxt;
      text_r <= text_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

[hw/rtl/terminal_key_sequence_decoder_core.sv]
// Top level of the terminal key sequence decoder.
// The block turns raw terminal bytes into key events, one event per byte.
// Input: in_tvalid/in_tready/in_tdata, one byte per request.
// Output: out_tvalid/out_tready/out_tdata, one key event per request.
// A control byte maps to an editing key, tab gives TAB_SPACES spaces, and
// UTF-8 characters, ESC word moves and CSI or SS3 sequences are assembled.
// Bytes that only advance a sequence give key code none.
// A byte passes a classify register, a two-entry queue and the decode
// register, in that order, before its event appears. While out_tready is
// high, one byte is accepted and one event is given every cycle; the decode
// register holds the sequence state and closes the only feedback loop.
// When the receiver stalls, the queue and the input register fill and
// in_tready falls once four requests are held; no request is lost.
// Reset clears all sequence state and empties the queue and output.
`timescale 1ns / 1ps
module terminal_key_sequence_decoder_core #(
  parameter int TAB_SPACES  = 4,
  parameter int PARAM_LIMIT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // [4:0] key_code, [68:5] text_bytes, [72:69] text_len
);
  import tksd_pkg::*;

  logic       push_valid, push_ready;
  tksd_item_t push_item;
  logic       q_valid, q_pop;
  tksd_item_t q_item;
  logic [4:0]  key_code;
  logic [63:0] text_bytes;
  logic [3:0]  text_len;

  tksd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  tksd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_item  (q_item)
  );

  tksd_back #(
    .TAB_SPACES  (TAB_SPACES),
    .PARAM_LIMIT (PARAM_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .key_code   (key_code),
    .text_bytes (text_bytes),
    .text_len   (text_len)
  );

  assign out_tdata = {7'b0, text_len, text_bytes, key_code};

endmodule

[hw/rtl/tksd_checker.sv]
// Port-level checker for the terminal key sequence decoder and its bind.
`timescale 1ns / 1ps
module tksd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);
  import tksd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output request changed");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:0] <= K_IGNORED && out_tdata[72:69] <= 4'd8)
    else $error("key code or text length out of range");

  a_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4:0] != K_CHAR |->
      out_tdata[72:69] == 4'd0 && out_tdata[68:5] == 64'd0)
    else $error("text present on a non-character key");

  a_char_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4:0] == K_CHAR |-> out_tdata[72:69] != 4'd0)
    else $error("character key with no text");

endmodule

bind terminal_key_sequence_decoder_core tksd_checker u_tksd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
